// ===== src/pfe_pkg.sv =====
package pfe_pkg;

    // ASCII codes used by the formatter
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    // Operation of the shared shift unit
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_DABBLE,
        OP_NIBBLE
    } t_op;

    // Map one digit to its uppercase ASCII character
    function automatic logic [7:0] digit_ascii(input logic [3:0] nib);
        logic [7:0] code;
        if (nib < 4'd10) begin
            code = CH_ZERO + {4'd0, nib};
        end else begin
            code = CH_UPPER_A + {4'd0, nib} - 8'd10;
        end
        return code;
    endfunction

endpackage

// ===== src/pfe_ifs.sv =====
interface pfe_in_if;
    logic              valid;
    logic              ready;
    logic [7:0]        format_char;
    logic signed [31:0] argument;

    modport source (output valid, output format_char, output argument, input ready);
    modport sink   (input valid, input format_char, input argument, output ready);
endinterface

interface pfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ===== src/printf_format_engine_unit.sv =====
// Plain character or %c: one item out, ready again once it is loaded into the output register.
// %x: "0x" plus (ARG_WIDTH+3)/4 digit positions, leading zero digits dropped.
// %d: double-dabble in the shared shift unit, then '-' if negative, then (3*ARG_WIDTH)/10+1
//     digit positions, leading zero digits dropped; ready again after the final digit.
// One item at a time; the output register lets a result wait for the sink.
// Synchronous active-low reset clears the sequencer, pending '%' and output valid.
module printf_format_engine_unit #(
    parameter int ARG_WIDTH = 32
) (
    input logic       i_clk,
    input logic       i_rst_n,
    pfe_in_if.sink    i_fmt,
    pfe_out_if.source o_res
);
    import pfe_pkg::*;

    localparam int DEC_DIGITS = (ARG_WIDTH * 3) / 10 + 1;
    localparam int HEX_DIGITS = (ARG_WIDTH + 3) / 4;
    localparam int DIG_W      = 4 * DEC_DIGITS;
    localparam int HEX_W      = 4 * HEX_DIGITS;
    localparam int HEX_SHIFT  = DIG_W - HEX_W;
    localparam int CNT_W      = $clog2(ARG_WIDTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EMIT1  = 3'd1;
    localparam logic [2:0] S_CONV   = 3'd2;
    localparam logic [2:0] S_PRE0   = 3'd3;
    localparam logic [2:0] S_PREX   = 3'd4;
    localparam logic [2:0] S_DIGITS = 3'd5;

    logic [2:0]           r_state, n_state;
    logic                 r_pending, n_pending;
    logic                 r_hex, n_hex;
    logic                 r_neg, n_neg;
    logic                 r_started, n_started;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [7:0]           r_char, n_char;
    logic [DIG_W-1:0]     r_dig, n_dig;
    logic [ARG_WIDTH-1:0] r_bin, n_bin;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    t_op                  op;
    logic [DIG_W-1:0]     u_dig;
    logic [ARG_WIDTH-1:0] u_bin;

    logic [63:0]          arg_ext;
    logic [ARG_WIDTH-1:0] word;
    logic [ARG_WIDTH-1:0] mag;
    logic [HEX_W-1:0]     word_hex;
    logic [3:0]           top_nib;
    logic                 out_free;
    logic                 skip;

    // Sign-extend the argument, cut to the formatted width
    assign arg_ext  = 64'(signed'(i_fmt.argument));
    assign word     = arg_ext[ARG_WIDTH-1:0];
    assign mag      = word[ARG_WIDTH-1] ? (~word + ARG_WIDTH'(1)) : word;
    assign word_hex = HEX_W'(word);

    assign top_nib  = r_dig[DIG_W-1 -: 4];
    assign out_free = !r_out_valid || o_res.ready;
    assign skip     = !r_started && (top_nib == 4'd0) && (r_cnt != CNT_W'(1));

    assign i_fmt.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.out_char = r_out_char;
    assign o_res.last     = r_out_last;

    pfe_shift_unit #(
        .DIG_W (DIG_W),
        .ARG_W (ARG_WIDTH)
    ) u_shift (
        .i_op  (op),
        .i_dig (r_dig),
        .i_bin (r_bin),
        .o_dig (u_dig),
        .o_bin (u_bin)
    );

    // Sequencer: decode the item, run the conversion, emit characters
    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_hex       = r_hex;
        n_neg       = r_neg;
        n_started   = r_started;
        n_cnt       = r_cnt;
        n_char      = r_char;
        n_dig       = r_dig;
        n_bin       = r_bin;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        op          = OP_HOLD;

        unique case (r_state)
            S_IDLE: begin
                if (i_fmt.valid) begin
                    if (!r_pending) begin
                        if (i_fmt.format_char == CH_PERCENT) begin
                            n_pending = 1'b1;
                        end else begin
                            n_char  = i_fmt.format_char;
                            n_state = S_EMIT1;
                        end
                    end else begin
                        n_pending = 1'b0;
                        case (i_fmt.format_char)
                            CH_D: begin
                                n_dig     = '0;
                                n_bin     = mag;
                                n_neg     = word[ARG_WIDTH-1];
                                n_hex     = 1'b0;
                                n_started = 1'b0;
                                n_cnt     = CNT_W'(ARG_WIDTH);
                                n_state   = S_CONV;
                            end
                            CH_X: begin
                                n_dig     = DIG_W'(word_hex) << HEX_SHIFT;
                                n_hex     = 1'b1;
                                n_started = 1'b0;
                                n_cnt     = CNT_W'(HEX_DIGITS);
                                n_state   = S_PRE0;
                            end
                            CH_C: begin
                                n_char  = word[7:0];
                                n_state = S_EMIT1;
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_EMIT1: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_char;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_CONV: begin
                // One double-dabble step per cycle
                op    = OP_DABBLE;
                n_dig = u_dig;
                n_bin = u_bin;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_cnt   = CNT_W'(DEC_DIGITS);
                    n_state = r_neg ? S_PRE0 : S_DIGITS;
                end
            end
            S_PRE0: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_hex ? CH_ZERO : CH_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = r_hex ? S_PREX : S_DIGITS;
                end
            end
            S_PREX: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_X;
                    n_out_last  = 1'b0;
                    n_state     = S_DIGITS;
                end
            end
            S_DIGITS: begin
                // Drop leading zero digits, emit the rest, keep the final digit
                if (out_free) begin
                    op    = OP_NIBBLE;
                    n_dig = u_dig;
                    n_cnt = r_cnt - CNT_W'(1);
                    if (!skip) begin
                        n_out_valid = 1'b1;
                        n_out_char  = digit_ascii(top_nib);
                        n_out_last  = (r_cnt == CNT_W'(1));
                        n_started   = 1'b1;
                    end
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // Work and output payload registers
    always_ff @(posedge i_clk) begin
        r_hex      <= n_hex;
        r_neg      <= n_neg;
        r_started  <= n_started;
        r_cnt      <= n_cnt;
        r_char     <= n_char;
        r_dig      <= n_dig;
        r_bin      <= n_bin;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

// ===== src/pfe_shift_unit.sv =====
module pfe_shift_unit #(
    parameter int DIG_W = 40,
    parameter int ARG_W = 32
) (
    input  pfe_pkg::t_op     i_op,
    input  logic [DIG_W-1:0] i_dig,
    input  logic [ARG_W-1:0] i_bin,
    output logic [DIG_W-1:0] o_dig,
    output logic [ARG_W-1:0] o_bin
);
    import pfe_pkg::*;

    localparam int NDIG = DIG_W / 4;

    logic [DIG_W-1:0] adj;

    // Add three to every BCD digit of five or more
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            adj[4*k +: 4] = (i_dig[4*k +: 4] >= 4'd5) ? i_dig[4*k +: 4] + 4'd3
                                                      : i_dig[4*k +: 4];
        end
    end

    // Shift one binary bit into the digits, drop the top digit, or hold both
    always_comb begin
        unique case (i_op)
            OP_DABBLE: begin
                {o_dig, o_bin} = {adj, i_bin} << 1;
            end
            OP_NIBBLE: begin
                o_dig = i_dig << 4;
                o_bin = i_bin;
            end
            default: begin
                o_dig = i_dig;
                o_bin = i_bin;
            end
        endcase
    end

endmodule

// ===== src/pfe_checker.sv =====
module pfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("stalled output item changed");

    // Input is taken only when any waiting output is the final one of its item
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_last)
        else $error("ready for input with a non-final output waiting");

    // A stalled non-final character keeps the input blocked
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready && !i_out_last |=> !i_in_ready)
        else $error("ready for input in the middle of an item");

endmodule

bind printf_format_engine_unit pfe_checker u_pfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_fmt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_char  (o_res.out_char),
    .i_out_last  (o_res.last)
);

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          RANDOM_ITEMS = 353;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [7:0]  CH_NUL       = 8'h00;
    localparam logic [7:0]  CH_TOP       = 8'hFF;
    localparam logic [7:0]  CH_L         = 8'h6C;
    localparam logic [7:0]  CH_Q         = 8'h71;

    typedef struct {
        logic [7:0]  ch;
        logic [31:0] arg;
    } t_fmt_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_text_char;

    logic i_clk;
    logic i_rst_n;

    pfe_in_if  fmt_if ();
    pfe_out_if res_if ();

    printf_format_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fmt   (fmt_if),
        .o_res   (res_if)
    );

    t_fmt_item  fmt_items[$];
    t_text_char expected_text[$];

    bit pct_armed;
    int items_sent;
    int chars_checked;
    int mismatch_count;
    int cycle_count;
    int n_dec;
    int n_hex;
    int n_chr;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Append the characters one format item should produce
    function automatic void format_into_expected(input logic [7:0] ch, input logic [31:0] arg);
        t_text_char chars[$];
        logic [7:0] digits[$];
        logic [31:0] mag;
        logic [3:0] nib;
        int top;
        chars = {};
        digits = {};
        if (!pct_armed) begin
            if (ch == CH_PERCENT) begin
                pct_armed = 1'b1;
                return;
            end
            chars.push_back('{ch, 1'b0});
        end else begin
            pct_armed = 1'b0;
            if (ch == CH_D) begin
                n_dec++;
                mag = arg;
                if (arg[31]) begin
                    chars.push_back('{CH_MINUS, 1'b0});
                    mag = ~arg + 32'd1;
                end
                do begin
                    digits.push_front(CH_ZERO + 8'(mag % 32'd10));
                    mag = mag / 32'd10;
                end while (mag != 0);
                foreach (digits[i]) chars.push_back('{digits[i], 1'b0});
            end else if (ch == CH_X) begin
                n_hex++;
                chars.push_back('{CH_ZERO, 1'b0});
                chars.push_back('{CH_X, 1'b0});
                top = 0;
                for (int i = 0; i < 8; i++) begin
                    if (arg[4*i +: 4] != 4'd0) top = i;
                end
                for (int i = top; i >= 0; i--) begin
                    nib = arg[4*i +: 4];
                    chars.push_back('{(nib < 4'd10) ? CH_ZERO + 8'(nib)
                                                    : CH_UPPER_A + 8'(nib) - 8'd10, 1'b0});
                end
            end else if (ch == CH_C) begin
                n_chr++;
                chars.push_back('{arg[7:0], 1'b0});
            end else begin
                return;
            end
        end
        chars[chars.size() - 1].last = 1'b1;
        foreach (chars[i]) expected_text.push_back(chars[i]);
    endfunction

    // Pick an argument shaped toward short, long, negative and extreme values
    function automatic logic [31:0] random_arg();
        logic [31:0] v;
        int w;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 9);
            2: v = -$urandom_range(1, 1000);
            3: begin
                w = $urandom_range(1, 32);
                v = $urandom & (32'hFFFF_FFFF >> (32 - w));
                if ($urandom_range(0, 1)) v = -v;
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h0000_0000;
                    1: v = 32'h8000_0000;
                    2: v = 32'h7FFF_FFFF;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom_range(0, 99999);
        endcase
        return v;
    endfunction

    function automatic void add_item(input logic [7:0] ch, input logic [31:0] arg);
        fmt_items.push_back('{ch, arg});
    endfunction

    // Sender: bursts of items separated by random gaps; hold the item until taken
    always @(posedge i_clk) begin : drive_proc
        int  burst_left;
        int  gap_left;
        bit  taken;
        if (!i_rst_n) begin
            fmt_if.valid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            taken = fmt_if.valid && fmt_if.ready;
            if (taken) begin
                format_into_expected(fmt_if.format_char, fmt_if.argument);
                void'(fmt_items.pop_front());
                items_sent++;
            end
            if (fmt_if.valid && !taken) begin
                // hold the offered item
            end else if (gap_left > 0) begin
                gap_left--;
                fmt_if.valid <= 1'b0;
            end else if (fmt_items.size() > 0) begin
                fmt_if.valid       <= 1'b1;
                fmt_if.format_char <= fmt_items[0].ch;
                fmt_if.argument    <= fmt_items[0].arg;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                fmt_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each output character against the oldest expected one, stall on its own pattern
    always @(posedge i_clk) begin : check_proc
        t_text_char want;
        int  hold_left;
        int  holds_done;
        int  next_hold_at;
        int  mode;
        int  mode_left;
        int  phase;
        bit  ready_next;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left = 0;
            holds_done = 0;
            next_hold_at = 150;
            mode = 0;
            mode_left = 40;
            phase = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                chars_checked++;
                if (expected_text.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected char 0x%02h last=%0b", $time,
                             res_if.out_char, res_if.last);
                end else begin
                    want = expected_text.pop_front();
                    if (res_if.out_char !== want.out_char) begin
                        mismatch_count++;
                        $display("%0t: out_char expected 0x%02h actual 0x%02h", $time,
                                 want.out_char, res_if.out_char);
                    end
                    if (res_if.last !== want.last) begin
                        mismatch_count++;
                        $display("%0t: last expected %0b actual %0b", $time,
                                 want.last, res_if.last);
                    end
                end
            end

            phase++;
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (holds_done < 2 && chars_checked >= next_hold_at) begin
                // long hold-off so the block backs up into its input
                hold_left = HOLD_CYCLES;
                holds_done++;
                next_hold_at += 700;
                ready_next = 1'b0;
            end else begin
                mode_left--;
                if (mode_left <= 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 90);
                end
                case (mode)
                    0: ready_next = 1'b1;
                    1: ready_next = ($urandom_range(0, 9) < 7);
                    2: ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = (phase % 4 != 0);
                endcase
            end
            res_if.ready <= ready_next;
        end
    end

    // End the run if it stalls
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d items left, %0d chars still expected", $time,
                     fmt_items.size(), expected_text.size());
            $display("** printf_format_engine_unit: FAILED **");
            $finish;
        end
    end

    initial begin : stim_proc
        int counted;
        logic [7:0] letter;
        i_rst_n = 1'b0;
        fmt_if.valid = 1'b0;
        fmt_if.format_char = CH_NUL;
        fmt_if.argument = '0;
        res_if.ready = 1'b0;

        // Directed: plain extremes, each conversion at its edge values, odd letters
        add_item(CH_UPPER_A, 32'h0);
        add_item(CH_NUL, 32'hFFFF_FFFF);
        add_item(CH_TOP, 32'h0);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_D, 32'h0000_0000);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_D, 32'h8000_0000);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_D, 32'h7FFF_FFFF);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_D, 32'hFFFF_FFFF);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_X, 32'h0000_0000);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_X, 32'hFFFF_FFFF);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_X, 32'h0000_ABCD);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_C, 32'hDEAD_BEFF);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_PERCENT, 32'h1234_5678);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_L, 32'h1);
        add_item(CH_PERCENT, 32'h0);  add_item(CH_Q, 32'h2);

        // Random: well-formed conversions mixed with plain text and broken sequences
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8: letter = CH_D;
                        9, 10, 11, 12, 13, 14, 15: letter = CH_X;
                        default: letter = CH_C;
                    endcase
                    add_item(CH_PERCENT, $urandom);
                    add_item(letter, random_arg());
                    counted += 2;
                end
                5, 6, 7: begin
                    add_item(8'($urandom_range(0, 255)), $urandom);
                    counted++;
                end
                8: begin
                    add_item(CH_PERCENT, $urandom);
                    add_item(8'($urandom_range(0, 255)), random_arg());
                    counted += 2;
                end
                default: begin
                    add_item(CH_PERCENT, $urandom);
                    add_item($urandom_range(0, 1) ? CH_PERCENT : CH_L, $urandom);
                    counted += 2;
                end
            endcase
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item is taken and every expected char has come out
        do begin
            @(posedge i_clk);
        end while (fmt_items.size() != 0 || fmt_if.valid || expected_text.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d format items (%0d %%d, %0d %%x, %0d %%c conversions),",
                 items_sent, n_dec, n_hex, n_chr);
        $display("checked %0d output chars, %0d mismatches.", chars_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("** printf_format_engine_unit: PASSED **");
        end else begin
            $display("** printf_format_engine_unit: FAILED **");
        end
        $finish;
    end

endmodule
